### hw/rtl/cle_pkg.sv
// cle_pkg: shared types and constants for the circular list engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cle_pkg;
   localparam int CapacityDefault = 16;

   localparam logic [2:0] ReqInsHead = 3'd0;
   localparam logic [2:0] ReqInsTail = 3'd1;
   localparam logic [2:0] ReqInsPos  = 3'd2;
   localparam logic [2:0] ReqDelVal  = 3'd3;
   localparam logic [2:0] ReqDelPos  = 3'd4;
   localparam logic [2:0] ReqFind    = 3'd5;
   localparam logic [2:0] ReqList    = 3'd6;
   localparam logic [2:0] ReqNone    = 3'd7;

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StBadPos   = 3'd1;
   localparam logic [2:0] StNotFound = 3'd2;
   localparam logic [2:0] StFull     = 3'd3;
   localparam logic [2:0] StEmpty    = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_WALK, S_READ, S_LINK, S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic retarget;  // turn a value delete into a positional delete
      logic walk_init; // cursor to head
      logic walk_step; // cursor to next link
      logic rd;        // read element/link at cursor
      logic do_insert;
      logic do_remove;
      logic emit;      // drive one result
      logic [2:0] status;
      logic found;
      logic last;
      logic with_elem;
   } cmd_type;
endpackage
`default_nettype wire

### hw/rtl/cle_datapath.sv
// cle_datapath: element and link stores, head, count, free map, walk cursor
// depends on cle_pkg
`timescale 1ns / 1ps
`default_nettype none
module cle_datapath #(
   parameter int CAPACITY = cle_pkg::CapacityDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire cle_pkg::cmd_type              cmd,
   input  wire logic [2:0]                    req_type,
   input  wire logic signed [31:0]            req_value,
   input  wire logic [6:0]                    req_position,
   output logic [2:0]                         op_ff,
   output logic [6:0]                         pos_ff,
   output logic [$clog2(CAPACITY+1)-1:0]      count_ff,
   output logic [$clog2(CAPACITY+1)-1:0]      step_ff,
   output logic                               match,
   output logic                               rsp_strobe,
   output logic [2:0]                         rsp_status,
   output logic signed [31:0]                 rsp_element,
   output logic                               rsp_found,
   output logic                               rsp_last
);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic signed [31:0] elem_mem [CAPACITY];
   logic [IW-1:0]      link_mem [CAPACITY];
   logic [IW-1:0]      head_ff, cur_ff, prev_ff, slot;
   logic [CAPACITY-1:0] free_ff;
   logic signed [31:0] value_ff, rd_elem_ff;
   logic [IW-1:0]      rd_link_ff;

   // lowest free slot
   always_comb begin
      slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--)
         if (free_ff[i]) slot = IW'(i);
   end

   assign match = (rd_elem_ff == value_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_elem_ff <= elem_mem[cur_ff];
         rd_link_ff <= link_mem[cur_ff];
      end
      if (cmd.do_insert) begin
         elem_mem[slot] <= value_ff;
         if (count_ff == '0) link_mem[slot] <= slot;
         else begin
            link_mem[slot] <= rd_link_ff;
            link_mem[prev_ff] <= slot;
         end
      end
      if (cmd.do_remove) link_mem[prev_ff] <= link_mem[rd_link_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         free_ff <= '1;
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= cmd.emit;
         if (cmd.do_insert) begin
            free_ff[slot] <= 1'b0;
            count_ff <= count_ff + 1'b1;
            if (count_ff == '0 || pos_ff == 7'd1) head_ff <= slot;
         end
         if (cmd.do_remove) begin
            free_ff[rd_link_ff] <= 1'b1;
            count_ff <= count_ff - 1'b1;
            if (count_ff == CW'(1)) head_ff <= '0;
            else if (pos_ff == 7'd1) head_ff <= link_mem[rd_link_ff];
         end
      end
   end

   // walk cursor: prev trails cur by one link
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_type;
         value_ff <= req_value;
         case (req_type)
            cle_pkg::ReqInsHead: pos_ff <= 7'd1;
            cle_pkg::ReqInsTail: pos_ff <= 7'(count_ff) + 7'd1;
            default:             pos_ff <= req_position;
         endcase
      end else if (cmd.retarget) begin
         // matched element sits at 1-based position step + 1
         op_ff <= cle_pkg::ReqDelPos;
         pos_ff <= 7'(step_ff) + 7'd1;
      end
      if (cmd.walk_init) begin
         cur_ff <= head_ff;
         step_ff <= '0;
      end else if (cmd.walk_step) begin
         prev_ff <= cur_ff;
         cur_ff <= rd_link_ff;
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.emit) begin
         rsp_status <= cmd.status;
         rsp_found <= cmd.found;
         rsp_last <= cmd.last;
         rsp_element <= cmd.with_elem ? rd_elem_ff : 32'sd0;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.do_insert |-> count_ff < CW'(CAPACITY))
      else $error("insert into full store");
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_remove |-> count_ff != '0)
      else $error("remove from empty list");
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_insert && cmd.do_remove))
      else $error("insert and remove together");
endmodule
`default_nettype wire

### hw/rtl/cle_control.sv
// cle_control: request sequencer for the circular list engine
// depends on cle_pkg
`timescale 1ns / 1ps
`default_nettype none
module cle_control #(
   parameter int CAPACITY = cle_pkg::CapacityDefault
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_type,
   input  wire logic [2:0]                    op_ff,
   input  wire logic [6:0]                    pos_ff,
   input  wire logic [$clog2(CAPACITY+1)-1:0] count_ff,
   input  wire logic [$clog2(CAPACITY+1)-1:0] step_ff,
   input  wire logic                          match,
   output cle_pkg::cmd_type                   cmd
);
   localparam int CW = $clog2(CAPACITY + 1);
   cle_pkg::state_type state_ff, state_in;
   logic [CW-1:0] target;
   logic [6:0] cnt7;

   assign cnt7 = 7'(count_ff);
   // walk target: prev of 0-based position p is (p==0 ? count-1 : p-1) links from head
   always_comb begin
      if (pos_ff == 7'd1) target = count_ff - 1'b1;
      else target = CW'(pos_ff - 7'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= cle_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != cle_pkg::S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         cle_pkg::S_IDLE: begin
            if (start && req_type != cle_pkg::ReqNone) begin
               cmd.load = 1'b1;
               state_in = cle_pkg::S_CHECK;
            end
         end
         cle_pkg::S_CHECK: begin
            cmd.walk_init = 1'b1;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            state_in = cle_pkg::S_DONE;
            unique case (op_ff)
               cle_pkg::ReqInsHead, cle_pkg::ReqInsTail, cle_pkg::ReqInsPos: begin
                  if (count_ff == CW'(CAPACITY)) cmd.status = cle_pkg::StFull;
                  else if (pos_ff != 7'd1 && (pos_ff < 7'd2 || pos_ff > cnt7)
                           && op_ff == cle_pkg::ReqInsPos)
                     cmd.status = cle_pkg::StBadPos;
                  else if (count_ff == '0) begin
                     cmd.emit = 1'b0;
                     cmd.do_insert = 1'b1;
                     cmd.walk_init = 1'b0;
                  end else begin
                     cmd.emit = 1'b0;
                     state_in = cle_pkg::S_READ;
                  end
               end
               cle_pkg::ReqDelPos: begin
                  if (count_ff == '0) cmd.status = cle_pkg::StEmpty;
                  else if (pos_ff < 7'd1 || pos_ff > cnt7) cmd.status = cle_pkg::StBadPos;
                  else begin
                     cmd.emit = 1'b0;
                     state_in = cle_pkg::S_READ;
                  end
               end
               default: begin
                  if (count_ff == '0) cmd.status = cle_pkg::StEmpty;
                  else begin
                     cmd.emit = 1'b0;
                     state_in = cle_pkg::S_READ;
                  end
               end
            endcase
         end
         cle_pkg::S_READ: begin
            cmd.rd = 1'b1;
            state_in = cle_pkg::S_WALK;
         end
         cle_pkg::S_WALK: begin
            // rd data holds element and link of cursor at step_ff
            unique case (op_ff)
               cle_pkg::ReqFind, cle_pkg::ReqList, cle_pkg::ReqDelVal: begin
                  if (op_ff == cle_pkg::ReqList) begin
                     cmd.emit = 1'b1;
                     cmd.with_elem = 1'b1;
                     cmd.status = cle_pkg::StOk;
                     cmd.last = (step_ff == count_ff - 1'b1);
                     if (cmd.last) state_in = cle_pkg::S_DONE;
                     else begin
                        cmd.walk_step = 1'b1;
                        state_in = cle_pkg::S_READ;
                     end
                  end else if (match) begin
                     if (op_ff == cle_pkg::ReqFind) begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                        cmd.found = 1'b1;
                        cmd.status = cle_pkg::StOk;
                        state_in = cle_pkg::S_DONE;
                     end else begin
                        // re-walk to the predecessor as a positional delete
                        cmd.retarget = 1'b1;
                        cmd.walk_init = 1'b1;
                        state_in = cle_pkg::S_READ;
                     end
                  end else if (step_ff == count_ff - 1'b1) begin
                     cmd.emit = 1'b1;
                     cmd.last = 1'b1;
                     cmd.status = cle_pkg::StNotFound;
                     state_in = cle_pkg::S_DONE;
                  end else begin
                     cmd.walk_step = 1'b1;
                     state_in = cle_pkg::S_READ;
                  end
               end
               default: begin
                  // insert or positional delete: walk to predecessor
                  cmd.walk_step = 1'b1;
                  if (step_ff == target) state_in = cle_pkg::S_LINK;
                  else state_in = cle_pkg::S_READ;
               end
            endcase
         end
         cle_pkg::S_LINK: begin
            if (op_ff == cle_pkg::ReqDelPos) cmd.do_remove = 1'b1;
            else cmd.do_insert = 1'b1;
            cmd.emit = 1'b1;
            cmd.last = 1'b1;
            cmd.status = cle_pkg::StOk;
            state_in = cle_pkg::S_DONE;
         end
         cle_pkg::S_DONE: begin
            state_in = cle_pkg::S_IDLE;
         end
         default: state_in = cle_pkg::S_IDLE;
      endcase
      // insert into empty list finishes in check state
      if (state_ff == cle_pkg::S_CHECK && cmd.do_insert) begin
         cmd.emit = 1'b1;
         cmd.last = 1'b1;
         cmd.status = cle_pkg::StOk;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.last |=> state_ff == cle_pkg::S_DONE || state_ff == cle_pkg::S_IDLE)
      else $error("final result without finishing");
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load)
      else $error("load while busy");
   assert property (@(posedge clock) disable iff (reset)
      cmd.found |-> cmd.emit && cmd.status == cle_pkg::StOk)
      else $error("found without ok result");
endmodule
`default_nettype wire

### hw/rtl/circular_list_engine_unit.sv
// circular_list_engine_unit: top level of the circular list engine
// depends on cle_pkg, cle_control, cle_datapath
//
// channel   direction  handshake
// request   in         start & !busy: req_type, req_value, req_position
// response  out        rsp_strobe: rsp_status, rsp_element, rsp_found, rsp_last
//
// a status-only request ends in the check state; otherwise find and list walk
// n list nodes, and insert and delete walk n nodes and then relink in S_LINK;
// n is at most CAPACITY, but a delete by value walks again from the head, so
// up to 2*CAPACITY nodes in all. the walk loop reads one element and link per
// node from the stores; list-all emits one result per element.
// reset clears head, count and free map; no clearing pass.
// results cannot be stalled; busy stays high until the request is done.
`timescale 1ns / 1ps
`default_nettype none
module circular_list_engine_unit #(
   parameter int CAPACITY = cle_pkg::CapacityDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_type,
   input  wire logic signed [31:0] req_value,
   input  wire logic [6:0]         req_position,
   output logic                    rsp_strobe,
   output logic [2:0]              rsp_status,
   output logic signed [31:0]      rsp_element,
   output logic                    rsp_found,
   output logic                    rsp_last
);
   localparam int CW = $clog2(CAPACITY + 1);
   cle_pkg::cmd_type cmd;
   logic [2:0] op_ff;
   logic [6:0] pos_ff;
   logic [CW-1:0] count_ff, step_ff;
   logic match;

   cle_control #(.CAPACITY(CAPACITY)) u_ctrl (
      .clock, .reset, .start, .busy, .req_type, .op_ff, .pos_ff,
      .count_ff, .step_ff, .match, .cmd
   );

   cle_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock, .reset, .cmd, .req_type, .req_value, .req_position,
      .op_ff, .pos_ff, .count_ff, .step_ff, .match,
      .rsp_strobe, .rsp_status, .rsp_element, .rsp_found, .rsp_last
   );
endmodule
`default_nettype wire
